### hw/rtl/brlc_pkg.sv
// shared types and constants of the beat repeat loop crossfade block
`default_nettype none

package brlc_pkg;

  // one lane per stereo channel: lane 0 left, lane 1 right
  localparam int unsigned LANES = 2;

  // fixed field widths of the input transaction
  localparam int unsigned DIV_LEN_W = 20;
  localparam int unsigned TAG_W     = 8;

  // control from the sequencer to the merge stage
  typedef struct packed {
    logic load;       // take a result into the output register
    logic use_mix;    // lanes carry a crossfaded value
    logic repeating;  // result is replayed from the capture store
  } out_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/brlc_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module brlc_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 262144
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/brlc_lane.sv
// one channel lane: crossfade mix with a bit-serial divider
`default_nettype none

module brlc_lane #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned FADE_W      = 9
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [SAMPLE_BITS-1:0] tail_i,
  input  wire logic signed [SAMPLE_BITS-1:0] head_i,
  input  wire logic        [FADE_W-1:0]      mul_i,
  input  wire logic        [FADE_W-1:0]      div_i,
  output logic                               done_o,
  output logic signed [SAMPLE_BITS-1:0]      mix_o
);

  // quotient magnitude never exceeds |head - tail|
  localparam int unsigned QW = SAMPLE_BITS + 1;
  localparam int unsigned PW = SAMPLE_BITS + FADE_W + 2;
  localparam int unsigned IW = $clog2(QW);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MAG  = 4'b0010,
    L_DIV  = 4'b0100,
    L_DONE = 4'b1000
  } lane_state_e;

  lane_state_e state_q, state_d;
  logic [IW-1:0] iter_q, iter_d;

  logic signed [PW-1:0]          prod_q;
  logic signed [SAMPLE_BITS-1:0] tail_q;
  logic        [FADE_W-1:0]      div_q;
  logic                          neg_q, neg_d;
  logic        [FADE_W-1:0]      rem_q, rem_d;
  logic        [QW-1:0]          quo_q, quo_d;

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FADE_W:0]        mul_s;
  logic signed [PW-1:0]          prod;
  logic        [PW-1:0]          mag;
  logic        [FADE_W:0]        shift_val;
  logic        [FADE_W:0]        div_x;
  logic                          ge;
  logic signed [QW:0]            quo_s;
  logic signed [QW:0]            sum;

  // weighted difference, registered before the divider
  assign diff  = $signed({head_i[SAMPLE_BITS-1], head_i})
               - $signed({tail_i[SAMPLE_BITS-1], tail_i});
  assign mul_s = $signed({1'b0, mul_i});
  assign prod  = diff * mul_s;

  // magnitude for unsigned division, truncation toward zero
  assign mag = prod_q[PW-1] ? (~prod_q + PW'(1)) : prod_q;

  // one restoring division step
  assign div_x     = {1'b0, div_q};
  assign shift_val = {rem_q, quo_q[QW-1]};
  assign ge        = (shift_val >= div_x);

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    neg_d   = neg_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    case (state_q)
      L_IDLE, L_DONE: begin
        if (start_i) begin
          state_d = L_MAG;
        end
      end
      L_MAG: begin
        neg_d   = prod_q[PW-1];
        rem_d   = FADE_W'(mag >> QW);
        quo_d   = mag[QW-1:0];
        iter_d  = '0;
        state_d = L_DIV;
      end
      L_DIV: begin
        rem_d  = ge ? FADE_W'(shift_val - div_x) : FADE_W'(shift_val);
        quo_d  = {quo_q[QW-2:0], ge};
        iter_d = iter_q + IW'(1);
        if (iter_q == IW'(QW - 1)) begin
          state_d = L_DONE;
        end
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == L_IDLE || state_q == L_DONE)) begin
      prod_q <= prod;
      tail_q <= tail_i;
      div_q  <= div_i;
    end
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // signed quotient added back onto the tail sample
  assign quo_s  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign sum    = $signed({{2{tail_q[SAMPLE_BITS-1]}}, tail_q}) + quo_s;
  assign mix_o  = sum[SAMPLE_BITS-1:0];
  assign done_o = (state_q == L_DONE);

endmodule

`default_nettype wire

### hw/rtl/brlc_merge.sv
// merge stage: joins the lane results into the output register
`default_nettype none

module brlc_merge #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire brlc_pkg::out_ctl_t            ctl_i,
  input  wire logic signed [SAMPLE_BITS-1:0] mix_i [brlc_pkg::LANES],
  input  wire logic signed [SAMPLE_BITS-1:0] raw_i [brlc_pkg::LANES],
  output logic                               space_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      left_out_o,
  output logic signed [SAMPLE_BITS-1:0]      right_out_o,
  output logic                               repeating_o
);

  import brlc_pkg::*;

  logic                          valid_q, valid_d;
  logic signed [SAMPLE_BITS-1:0] res_q [LANES];
  logic                          rep_q;

  // output register is free when empty or drained this cycle
  assign space_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ctl_i.load) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // per lane select between mix and raw sample
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      for (int i = 0; i < LANES; i++) begin
        res_q[i] <= ctl_i.use_mix ? mix_i[i] : raw_i[i];
      end
      rep_q <= ctl_i.repeating;
    end
  end

  assign out_valid_o = valid_q;
  assign left_out_o  = res_q[0];
  assign right_out_o = res_q[1];
  assign repeating_o = rep_q;

endmodule

`default_nettype wire

### hw/rtl/beat_repeat_loop_crossfade.sv
// top level of the beat repeat loop crossfade block
`default_nettype none

// Beat repeat (stutter loop) with boundary crossfade, one stereo sample per
// transaction. A region starts when in_region rises, the tag changes inside a
// region, or restart is set with in_region high. The first L samples of a
// region (L = division_len clamped to 1..CAPTURE_DEPTH) are recorded into the
// capture ram and passed through, their last F = min(MAX_FADE, L/2) samples
// crossfaded toward the loop head; afterwards the capture is replayed from
// position F with the loop end crossfaded again, and repeating_o is high.
// Samples outside a region pass unchanged. One sample is processed at a time:
// a pass-through sample goes from acceptance through the region and plan
// steps to the output register, a capture sample also writes the ram, a
// replay sample first reads its tail from the ram, and a crossfaded sample
// waits on the bit-serial divider in each channel lane; both lanes run side
// by side. The capture ram has one write and one read port, and its reads
// are registered. A new sample can be accepted while the previous result
// waits in the output register. The ram content is undefined after reset
// and needs no clearing.
module beat_repeat_loop_crossfade #(
  parameter int unsigned CAPTURE_DEPTH = 262144,
  parameter int unsigned MAX_FADE      = 256,
  parameter int unsigned SAMPLE_BITS   = 24
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]        left_in_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        right_in_i,
  input  wire logic                                 in_region_i,
  input  wire logic        [brlc_pkg::TAG_W-1:0]    region_tag_i,
  input  wire logic        [brlc_pkg::DIV_LEN_W-1:0] division_len_i,
  input  wire logic                                 restart_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]             left_out_o,
  output logic signed [SAMPLE_BITS-1:0]             right_out_o,
  output logic                                      repeating_o
);

  import brlc_pkg::*;

  localparam int unsigned ADDR_W = $clog2(CAPTURE_DEPTH);
  localparam int unsigned LEN_W  = $clog2(CAPTURE_DEPTH + 1);
  localparam int unsigned FADE_W = $clog2(MAX_FADE + 1);
  localparam int unsigned WORD_W = LANES * SAMPLE_BITS;
  localparam logic [DIV_LEN_W:0] DEPTH_X = (DIV_LEN_W + 1)'(CAPTURE_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_REGION  = 8'b0000_0010,
    S_PLAN    = 8'b0000_0100,
    S_WRITE   = 8'b0000_1000,
    S_TAIL_RD = 8'b0001_0000,
    S_TAIL    = 8'b0010_0000,
    S_HEAD    = 8'b0100_0000,
    S_FIN     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // region state
  logic              active_q, active_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [FADE_W-1:0] fade_q, fade_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  rp_q, rp_d;

  // per transaction control
  logic              blend_q, blend_d;
  logic              rep_q, rep_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [FADE_W-1:0] f_q, f_d;

  // transaction payload
  logic signed [SAMPLE_BITS-1:0] samp_q [LANES];
  logic signed [SAMPLE_BITS-1:0] tail_q [LANES];
  logic signed [SAMPLE_BITS-1:0] head   [LANES];
  logic                          inreg_q;
  logic [TAG_W-1:0]              tagin_q;
  logic [DIV_LEN_W-1:0]          dlen_q;
  logic                          restart_q;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // lanes and merge
  logic                          lane_start;
  logic [FADE_W-1:0]             lane_mul;
  logic                          lane_done [LANES];
  logic signed [SAMPLE_BITS-1:0] lane_mix  [LANES];
  out_ctl_t                      mctl;
  logic                          space;

  // region start helpers
  logic              in_take;
  logic              act0;
  logic [DIV_LEN_W:0] dlen_x;
  logic [DIV_LEN_W:0] len_x;
  logic [LEN_W-1:0]  len_c;
  logic [LEN_W-1:0]  half_c;
  logic [FADE_W-1:0] fade_c;

  // capture and replay helpers
  logic [LEN_W-1:0]  start_c;
  logic              capturing;
  logic [LEN_W-1:0]  pos_c;
  logic [LEN_W-1:0]  pos_inc;
  logic [LEN_W-1:0]  fade_x;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;

  // requested length clamped to the store depth and its fade
  assign dlen_x = {1'b0, dlen_q};
  assign len_x  = (dlen_x == '0) ? (DIV_LEN_W + 1)'(1) :
                  (dlen_x > DEPTH_X) ? DEPTH_X : dlen_x;
  assign len_c  = LEN_W'(len_x);
  assign half_c = len_c >> 1;
  assign fade_c = (32'(half_c) > 32'(MAX_FADE)) ? FADE_W'(MAX_FADE) : FADE_W'(half_c);
  assign act0   = restart_q ? 1'b0 : active_q;

  // position of this sample within the capture
  assign fade_x    = LEN_W'(fade_q);
  assign start_c   = len_q - fade_x;
  assign capturing = (cnt_q < len_q);
  assign pos_c     = capturing ? cnt_q : rp_q;
  assign pos_inc   = pos_c + LEN_W'(1);

  // sequencer
  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    tag_d    = tag_q;
    len_d    = len_q;
    fade_d   = fade_q;
    cnt_d    = cnt_q;
    rp_d     = rp_q;
    blend_d  = blend_q;
    rep_d    = rep_q;
    pos_d    = pos_q;
    f_d      = f_q;
    ram_we     = 1'b0;
    ram_raddr  = pos_q;
    lane_start = 1'b0;
    mctl       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = S_REGION;
        end
      end
      S_REGION: begin
        if (inreg_q) begin
          if (!act0 || tagin_q != tag_q) begin
            active_d = 1'b1;
            tag_d    = tagin_q;
            len_d    = len_c;
            fade_d   = fade_c;
            cnt_d    = '0;
            rp_d     = '0;
          end
        end else begin
          active_d = 1'b0;
          len_d    = '0;
          fade_d   = '0;
          cnt_d    = '0;
          rp_d     = '0;
        end
        state_d = S_PLAN;
      end
      S_PLAN: begin
        blend_d = active_q && (fade_q != '0) && (pos_c >= start_c);
        rep_d   = active_q && !capturing;
        pos_d   = ADDR_W'(pos_c);
        f_d     = FADE_W'(pos_c - start_c);
        if (!active_q) begin
          state_d = S_FIN;
        end else if (capturing) begin
          cnt_d = pos_inc;
          if (pos_inc == len_q) begin
            rp_d = fade_x;
          end
          state_d = S_WRITE;
        end else begin
          rp_d    = (pos_inc >= len_q) ? fade_x : pos_inc;
          state_d = S_TAIL_RD;
        end
      end
      S_WRITE: begin
        // record the sample and fetch the loop head at once
        ram_we    = 1'b1;
        ram_raddr = ADDR_W'(f_q);
        state_d   = blend_q ? S_HEAD : S_FIN;
      end
      S_TAIL_RD: begin
        ram_raddr = pos_q;
        state_d   = S_TAIL;
      end
      S_TAIL: begin
        ram_raddr = ADDR_W'(f_q);
        state_d   = blend_q ? S_HEAD : S_FIN;
      end
      S_HEAD: begin
        lane_start = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (space && (!blend_q || (lane_done[0] && lane_done[1]))) begin
          mctl.load      = 1'b1;
          mctl.use_mix   = blend_q;
          mctl.repeating = rep_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and region state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= 1'b0;
      tag_q    <= '0;
      len_q    <= '0;
      fade_q   <= '0;
      cnt_q    <= '0;
      rp_q     <= '0;
      blend_q  <= 1'b0;
      rep_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      tag_q    <= tag_d;
      len_q    <= len_d;
      fade_q   <= fade_d;
      cnt_q    <= cnt_d;
      rp_q     <= rp_d;
      blend_q  <= blend_d;
      rep_q    <= rep_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      samp_q[0] <= left_in_i;
      samp_q[1] <= right_in_i;
      inreg_q   <= in_region_i;
      tagin_q   <= region_tag_i;
      dlen_q    <= division_len_i;
      restart_q <= restart_i;
    end
    pos_q <= pos_d;
    f_q   <= f_d;
    for (int i = 0; i < LANES; i++) begin
      if (state_q == S_PLAN) begin
        tail_q[i] <= samp_q[i];
      end else if (state_q == S_TAIL) begin
        tail_q[i] <= ram_rdata[(LANES - 1 - i) * SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
  end

  // store word packs left above right
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ram_wdata[(LANES - 1 - i) * SAMPLE_BITS +: SAMPLE_BITS] = samp_q[i];
      head[i] = ram_rdata[(LANES - 1 - i) * SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  brlc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPTURE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // one crossfade lane per channel
  assign lane_mul = f_q + FADE_W'(1);

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    brlc_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FADE_W      (FADE_W)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (lane_start),
      .tail_i  (tail_q[g]),
      .head_i  (head[g]),
      .mul_i   (lane_mul),
      .div_i   (fade_q),
      .done_o  (lane_done[g]),
      .mix_o   (lane_mix[g])
    );
  end

  brlc_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (mctl),
    .mix_i       (lane_mix),
    .raw_i       (tail_q),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .repeating_o (repeating_o)
  );

  // an active region always has a loop length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (len_q != '0))
    else $error("active region with zero loop length");

  // the capture count never passes the loop length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= len_q)
    else $error("capture count beyond loop length");

  // once captured, the replay position stays inside the loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && len_q != '0 && cnt_q == len_q) |-> (rp_q < len_q))
    else $error("replay position outside the loop");

  // both channel lanes finish in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(lane_done[0]) |-> lane_done[1])
    else $error("channel lanes out of step");

  // a result is only loaded when the output register has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mctl.load |-> (!out_valid_o || !out_stall_i))
    else $error("result loaded over a waiting result");

endmodule

`default_nettype wire

### tb/beat_repeat_loop_crossfade_check.sv
// checker for the beat repeat loop crossfade block: predicts and compares every output transaction
module beat_repeat_loop_crossfade_check #(
  parameter int unsigned CAPTURE_DEPTH = 262144,
  parameter int unsigned MAX_FADE      = 256,
  parameter int unsigned SAMPLE_BITS   = 24
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic                             in_stall_i,
  input  wire logic [SAMPLE_BITS-1:0]           left_in_i,
  input  wire logic [SAMPLE_BITS-1:0]           right_in_i,
  input  wire logic                             in_region_i,
  input  wire logic [brlc_pkg::TAG_W-1:0]       region_tag_i,
  input  wire logic [brlc_pkg::DIV_LEN_W-1:0]   division_len_i,
  input  wire logic                             restart_i,
  input  wire logic                             out_valid_i,
  input  wire logic                             out_stall_i,
  input  wire logic [SAMPLE_BITS-1:0]           left_out_i,
  input  wire logic [SAMPLE_BITS-1:0]           right_out_i,
  input  wire logic                             repeating_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
    logic                   repeating;
  } out_sample_t;

  // expected output samples, oldest first
  out_sample_t expected_q[$];
  int          fail_total   = 0;
  int          results_seen = 0;

  // shadow copy of the loop state
  longint      shadow_left[int unsigned];
  longint      shadow_right[int unsigned];
  logic        region_on   = 1'b0;
  logic [brlc_pkg::TAG_W-1:0] region_id = '0;
  int unsigned loop_len    = 0;
  int unsigned filled      = 0;
  int unsigned play_pos    = 0;
  int unsigned fade_len    = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    fail_total++;
  endtask

  // tail + trunc((head - tail) * (f + 1) / fade), exact in 64 bits
  function automatic longint crossfade(input longint tail, input longint head,
                                       input int unsigned f, input int unsigned fade);
    longint num;
    num = (head - tail) * longint'(f + 1);
    return tail + num / longint'(fade);
  endfunction

  function automatic longint as_sample(input logic [SAMPLE_BITS-1:0] raw);
    return longint'($signed(raw));
  endfunction

  task automatic clear_loop();
    loop_len = 0;
    filled   = 0;
    play_pos = 0;
    fade_len = 0;
  endtask

  // advance the shadow state by one input sample and form its output
  task automatic predict_sample(output out_sample_t res);
    longint      l;
    longint      r;
    int unsigned start;
    int unsigned pos;
    int unsigned f;
    logic        rep;
    l   = as_sample(left_in_i);
    r   = as_sample(right_in_i);
    rep = 1'b0;

    if (restart_i) begin
      region_on = 1'b0;
      clear_loop();
    end

    // region entry on rise, tag change or restart
    if (in_region_i) begin
      if (!region_on || region_tag_i != region_id) begin
        if (division_len_i == 0) loop_len = 1;
        else if (division_len_i > CAPTURE_DEPTH) loop_len = CAPTURE_DEPTH;
        else loop_len = 32'(division_len_i);
        region_on = 1'b1;
        region_id = region_tag_i;
        filled    = 0;
        play_pos  = 0;
        fade_len  = loop_len / 2;
        if (fade_len > MAX_FADE) fade_len = MAX_FADE;
      end
    end else if (region_on) begin
      region_on = 1'b0;
      clear_loop();
    end

    if (region_on) begin
      start = loop_len - fade_len;
      if (filled < loop_len) begin
        // capture phase, tail crossfaded toward the loop head
        pos = filled;
        shadow_left[pos]  = l;
        shadow_right[pos] = r;
        filled++;
        if (fade_len > 0 && pos >= start) begin
          f = pos - start;
          l = crossfade(l, shadow_left[f], f, fade_len);
          r = crossfade(r, shadow_right[f], f, fade_len);
        end
        if (filled == loop_len) play_pos = fade_len;
      end else begin
        // replay phase, loop end crossfaded again
        pos = play_pos;
        l = shadow_left[pos];
        r = shadow_right[pos];
        if (fade_len > 0 && pos >= start) begin
          f = pos - start;
          l = crossfade(l, shadow_left[f], f, fade_len);
          r = crossfade(r, shadow_right[f], f, fade_len);
        end
        rep = 1'b1;
        play_pos++;
        if (play_pos >= loop_len) play_pos = fade_len;
      end
    end

    res.left      = l[SAMPLE_BITS-1:0];
    res.right     = r[SAMPLE_BITS-1:0];
    res.repeating = rep;
  endtask

  // compare output transactions, then predict the accepted input transaction
  always @(posedge clk_i) begin
    out_sample_t want;
    out_sample_t fresh;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no sample pending", results_seen));
        end else begin
          want = expected_q.pop_front();
          if (left_out_i !== want.left) begin
            report_mismatch($sformatf("result %0d left_out got %0d expected %0d", results_seen,
                                      $signed(left_out_i), $signed(want.left)));
          end
          if (right_out_i !== want.right) begin
            report_mismatch($sformatf("result %0d right_out got %0d expected %0d", results_seen,
                                      $signed(right_out_i), $signed(want.right)));
          end
          if (repeating_i !== want.repeating) begin
            report_mismatch($sformatf("result %0d repeating got %b expected %b", results_seen,
                                      repeating_i, want.repeating));
          end
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_sample(fresh);
        expected_q.push_back(fresh);
      end
    end
    pending_o    <= expected_q.size();
    fail_count_o <= fail_total;
  end

endmodule

### tb/beat_repeat_loop_crossfade_test.sv
// testbench top for the beat repeat loop crossfade block: stimulus, watchdog and verdict
module beat_repeat_loop_crossfade_test;

  localparam int unsigned CAPTURE_DEPTH  = 262144;
  localparam int unsigned MAX_FADE       = 256;
  localparam int unsigned SAMPLE_BITS    = 24;
  localparam int unsigned TARGET_ITEMS   = 1450;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 100;

  logic                             clk_i;
  logic                             rst_ni         = 1'b0;
  logic                             in_valid_i     = 1'b0;
  logic                             in_stall_o;
  logic [SAMPLE_BITS-1:0]           left_in_i      = '0;
  logic [SAMPLE_BITS-1:0]           right_in_i     = '0;
  logic                             in_region_i    = 1'b0;
  logic [brlc_pkg::TAG_W-1:0]       region_tag_i   = '0;
  logic [brlc_pkg::DIV_LEN_W-1:0]   division_len_i = '0;
  logic                             restart_i      = 1'b0;
  logic                             out_valid_o;
  logic                             out_stall_i    = 1'b0;
  logic [SAMPLE_BITS-1:0]           left_out_o;
  logic [SAMPLE_BITS-1:0]           right_out_o;
  logic                             repeating_o;

  int          fail_count;
  int          pending;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  logic        calm_mode = 1'b0;

  beat_repeat_loop_crossfade #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH),
    .MAX_FADE      (MAX_FADE),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .left_in_i      (left_in_i),
    .right_in_i     (right_in_i),
    .in_region_i    (in_region_i),
    .region_tag_i   (region_tag_i),
    .division_len_i (division_len_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .repeating_o    (repeating_o)
  );

  beat_repeat_loop_crossfade_check #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH),
    .MAX_FADE      (MAX_FADE),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .left_in_i      (left_in_i),
    .right_in_i     (right_in_i),
    .in_region_i    (in_region_i),
    .region_tag_i   (region_tag_i),
    .division_len_i (division_len_i),
    .restart_i      (restart_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_out_i     (left_out_o),
    .right_out_i    (right_out_o),
    .repeating_i    (repeating_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // output side: random stall before each transaction
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = calm_mode ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // random sample, extremes now and then
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    if (sel == 1) return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    if (sel == 2) return SAMPLE_BITS'($urandom_range(0, 3) - 2);
    return SAMPLE_BITS'($urandom);
  endfunction

  // one input transaction after a random gap, called at a falling edge
  task automatic drive_sample(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r,
                              input logic in_reg, input logic [brlc_pkg::TAG_W-1:0] tag,
                              input logic [brlc_pkg::DIV_LEN_W-1:0] dlen, input logic restart);
    int unsigned gap;
    gap = calm_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    left_in_i      = l;
    right_in_i     = r;
    in_region_i    = in_reg;
    region_tag_i   = tag;
    division_len_i = dlen;
    restart_i      = restart;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  // stimulus and verdict
  initial begin
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    int unsigned kind;
    int unsigned sel;
    int unsigned eff_len;
    int unsigned span;
    int unsigned big_loops;
    logic [brlc_pkg::TAG_W-1:0]     tag;
    logic [brlc_pkg::TAG_W-1:0]     last_tag;
    logic [brlc_pkg::DIV_LEN_W-1:0] dlen;

    big_loops = 0;
    last_tag  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // pass through with extreme samples
    drive_sample(S_MIN, S_MAX, 1'b0, 8'hFF, 20'hFFFFF, 1'b0);
    // restart outside a region
    drive_sample(S_MAX, S_MIN, 1'b0, 8'h00, 20'h00000, 1'b1);
    // zero length counts as one, single sample repeats without fade
    drive_sample(24'h123456, 24'hFEDCBA, 1'b1, 8'h05, 20'h00000, 1'b0);
    drive_sample(pick_sample(), pick_sample(), 1'b1, 8'h05, 20'hFFFFF, 1'b0);
    drive_sample(pick_sample(), pick_sample(), 1'b1, 8'h05, 20'h00004, 1'b0);
    // tag change: length four, fade two, full-scale swings
    drive_sample(S_MAX, S_MIN, 1'b1, 8'h06, 20'h00004, 1'b0);
    drive_sample(S_MIN, S_MAX, 1'b1, 8'h06, 20'h00000, 1'b0);
    drive_sample(24'h000000, 24'hFFFFFF, 1'b1, 8'h06, 20'h00000, 1'b0);
    drive_sample(S_MAX, S_MIN, 1'b1, 8'h06, 20'h00000, 1'b0);
    repeat (5) drive_sample(pick_sample(), pick_sample(), 1'b1, 8'h06, 20'h00001, 1'b0);
    // restart inside a region with the same tag
    drive_sample(24'h111111, 24'h222222, 1'b1, 8'h06, 20'h00003, 1'b1);
    repeat (5) drive_sample(pick_sample(), pick_sample(), 1'b1, 8'h06, 20'h00002, 1'b0);
    // oversize lengths, capture only
    drive_sample(pick_sample(), pick_sample(), 1'b1, 8'hFF, 20'hFFFFF, 1'b0);
    drive_sample(pick_sample(), pick_sample(), 1'b1, 8'hFF, 20'hFFFFF, 1'b0);
    drive_sample(pick_sample(), pick_sample(), 1'b1, 8'hFF, 20'(CAPTURE_DEPTH), 1'b1);
    // leaving the region
    drive_sample(S_MIN, S_MIN, 1'b0, 8'hFF, 20'h00002, 1'b0);
    drive_sample(S_MAX, S_MAX, 1'b0, 8'h00, 20'h00002, 1'b0);

    // random part: mostly whole regions, some noise
    while (items_sent < TARGET_ITEMS) begin
      calm_mode = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        sel = $urandom_range(0, 99);
        if (sel < 4) dlen = '0;
        else if (sel < 60) dlen = 20'($urandom_range(1, 8));
        else if (sel < 88) dlen = 20'($urandom_range(9, 64));
        else if (sel < 93) dlen = 20'($urandom_range(65, 300));
        else if (sel < 96 && big_loops < 2)
          dlen = 20'($urandom_range(2 * MAX_FADE, 2 * MAX_FADE + 60));
        else dlen = 20'($urandom_range(CAPTURE_DEPTH, 20'hFFFFF));
        if (dlen >= 2 * MAX_FADE && dlen < CAPTURE_DEPTH) big_loops++;
        eff_len = (dlen == 0) ? 1 : (dlen > CAPTURE_DEPTH ? CAPTURE_DEPTH : dlen);
        if (eff_len >= CAPTURE_DEPTH) span = $urandom_range(1, 20);
        else if (eff_len > 64) span = eff_len + $urandom_range(0, 40);
        else span = eff_len + $urandom_range(0, 2 * eff_len + 3);
        do tag = 8'($urandom); while (tag == last_tag);
        last_tag = tag;
        // region head, sometimes flagged as a restart
        drive_sample(pick_sample(), pick_sample(), 1'b1, tag, dlen,
                     $urandom_range(0, 3) == 0);
        for (int unsigned i = 1; i < span; i++) begin
          drive_sample(pick_sample(), pick_sample(), 1'b1, tag, 20'($urandom),
                       $urandom_range(0, 99) < 2);
        end
        if ($urandom_range(0, 9) < 7) begin
          repeat ($urandom_range(1, 4)) begin
            drive_sample(pick_sample(), pick_sample(), 1'b0, 8'($urandom), 20'($urandom),
                         $urandom_range(0, 9) == 0);
          end
        end
      end else begin
        // noise: every field random
        repeat ($urandom_range(1, 6)) begin
          drive_sample(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)), 8'($urandom),
                       20'($urandom), $urandom_range(0, 4) == 0);
        end
      end
    end
    in_valid_i = 1'b0;
    calm_mode  = 1'b0;

    // drain and let the block settle
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/brlc_pkg.sv
hw/rtl/brlc_ram.sv
hw/rtl/brlc_lane.sv
hw/rtl/brlc_merge.sv
hw/rtl/beat_repeat_loop_crossfade.sv
tb/beat_repeat_loop_crossfade_check.sv
tb/beat_repeat_loop_crossfade_test.sv
